// ===== sv/rational_accumulator_alu_core_defines.svh =====
// Assertion macros for the rational accumulator ALU.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef RATIONAL_ACCUMULATOR_ALU_CORE_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_ALU_CORE_DEFINES_SVH

// Same-cycle implication check, masked during reset.
`define RAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication check, masked during reset.
`define RAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rac_pkg.sv =====
// Shared types and codes for the rational accumulator ALU.
// No dependencies; imported by controller, datapath and top level.
package rac_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned ReqW  = 3;

  // Request codes
  localparam logic [ReqW-1:0] REQ_LOAD   = 3'd0;
  localparam logic [ReqW-1:0] REQ_ADD    = 3'd1;
  localparam logic [ReqW-1:0] REQ_SUB    = 3'd2;
  localparam logic [ReqW-1:0] REQ_MUL    = 3'd3;
  localparam logic [ReqW-1:0] REQ_DIV    = 3'd4;
  localparam logic [ReqW-1:0] REQ_POWER  = 3'd5;
  localparam logic [ReqW-1:0] REQ_REDUCE = 3'd6;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 3'd7;

  typedef struct packed {
    logic        [ReqW-1:0]  req_type;
    logic signed [DataW-1:0] operand_num;
    logic signed [DataW-1:0] operand_den;
    logic signed [ExpW-1:0]  exponent;
  } rac_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_num;
    logic signed [DataW-1:0] result_den;
    logic                    error_flag;
  } rac_rsp_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLEAR,
    OP_ONE,
    OP_T1,
    OP_T2,
    OP_ADD_DQ,
    OP_SUB_DQ,
    OP_NP,
    OP_DQ,
    OP_NQ,
    OP_DP,
    OP_PN,
    OP_PD,
    OP_GSTEP,
    OP_GFIN,
    OP_DLOAD,
    OP_DSTEP,
    OP_FIXN,
    OP_FIXD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   capture;
    logic   commit;
    logic   err;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_neg;
    logic exp_zero;
    logic exp_one;
    logic gcd_done;
    logic g_zero;
  } dp_status_t;

endpackage

// ===== sv/rac_datapath.sv =====
// Datapath: accumulator, work registers, shared multiplier, binary GCD and
// restoring divider. Depends on rac_pkg.
module rac_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rac_pkg::rac_req_t   in_req_i,
  input  rac_pkg::dp_cmd_t    cmd_i,
  output rac_pkg::dp_status_t status_o,
  output rac_pkg::rac_rsp_t   out_rsp_o
);
  import rac_pkg::*;

  function automatic logic [DataW-1:0] mag32(input logic [DataW-1:0] v);
    mag32 = v[DataW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [DataW-1:0] acc_n_q, acc_d_q;
  logic [DataW-1:0] wn_q, wd_q, bn_q, bd_q, p_q, q_q, t1_q, t2_q;
  logic [ExpW-1:0]  exp_q;
  logic [DataW-1:0] ga_q, gb_q, g_q, quo_q, rem_q;
  logic [4:0]       k_q;
  rac_rsp_t         rsp_q;

  logic [DataW-1:0] mul_a, mul_b, prod;
  logic             gcd_done;
  logic [DataW:0]   div_sh, div_diff;

  // one shared 32x32 multiplier, low word kept
  always_comb begin
    mul_a = wd_q;
    mul_b = '0;
    case (cmd_i.op)
      OP_T1:                          begin mul_a = wn_q; mul_b = q_q; end
      OP_T2:                          begin mul_a = wd_q; mul_b = p_q; end
      OP_ADD_DQ, OP_SUB_DQ, OP_DQ:    begin mul_a = wd_q; mul_b = q_q; end
      OP_NP:                          begin mul_a = wn_q; mul_b = p_q; end
      OP_NQ:                          begin mul_a = wn_q; mul_b = q_q; end
      OP_DP:                          begin mul_a = wd_q; mul_b = p_q; end
      OP_PN:                          begin mul_a = wn_q; mul_b = bn_q; end
      OP_PD:                          begin mul_a = wd_q; mul_b = bd_q; end
      default:                        begin mul_a = wd_q; mul_b = '0; end
    endcase
  end

  assign prod     = DataW'(mul_a * mul_b);
  assign gcd_done = (ga_q == '0) || (gb_q == '0);
  assign div_sh   = {rem_q, quo_q[DataW-1]};
  assign div_diff = div_sh - {1'b0, g_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_n_q <= '0;
      acc_d_q <= DataW'(1);
    end else if (cmd_i.commit && !cmd_i.err) begin
      acc_n_q <= wn_q;
      acc_d_q <= wd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wn_q  <= acc_n_q;
      wd_q  <= acc_d_q;
      bn_q  <= acc_n_q;
      bd_q  <= acc_d_q;
      p_q   <= in_req_i.operand_num;
      q_q   <= in_req_i.operand_den;
      exp_q <= in_req_i.exponent;
      ga_q  <= mag32(acc_n_q);
      gb_q  <= mag32(acc_d_q);
      k_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD:   begin wn_q <= p_q; wd_q <= q_q; end
        OP_CLEAR:  begin wn_q <= '0; wd_q <= DataW'(1); end
        OP_ONE:    begin wn_q <= DataW'(1); wd_q <= DataW'(1); end
        OP_T1:     t1_q <= prod;
        OP_T2:     t2_q <= prod;
        OP_ADD_DQ: begin wn_q <= t1_q + t2_q; wd_q <= prod; end
        OP_SUB_DQ: begin wn_q <= t1_q - t2_q; wd_q <= prod; end
        OP_NP, OP_NQ, OP_PN: wn_q <= prod;
        OP_DQ, OP_DP:        wd_q <= prod;
        OP_PD: begin
          wd_q  <= prod;
          exp_q <= exp_q - ExpW'(1);
        end
        OP_GSTEP: begin
          if (!gcd_done) begin
            if (!ga_q[0] && !gb_q[0]) begin
              ga_q <= ga_q >> 1;
              gb_q <= gb_q >> 1;
              k_q  <= k_q + 5'd1;
            end else if (!ga_q[0]) begin
              ga_q <= ga_q >> 1;
            end else if (!gb_q[0]) begin
              gb_q <= gb_q >> 1;
            end else if (ga_q >= gb_q) begin
              ga_q <= ga_q - gb_q;
            end else begin
              gb_q <= gb_q - ga_q;
            end
          end
        end
        OP_GFIN:   g_q <= (ga_q | gb_q) << k_q;
        OP_DLOAD:  begin quo_q <= mag32(wn_q); rem_q <= '0; end
        OP_DSTEP: begin
          if (!div_diff[DataW]) begin
            rem_q <= div_diff[DataW-1:0];
            quo_q <= {quo_q[DataW-2:0], 1'b1};
          end else begin
            rem_q <= div_sh[DataW-1:0];
            quo_q <= {quo_q[DataW-2:0], 1'b0};
          end
        end
        OP_FIXN: begin
          wn_q  <= wn_q[DataW-1] ? (~quo_q + 1'b1) : quo_q;
          quo_q <= mag32(wd_q);
          rem_q <= '0;
        end
        OP_FIXD:   wd_q <= wd_q[DataW-1] ? (~quo_q + 1'b1) : quo_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.result_num <= cmd_i.err ? acc_n_q : wn_q;
      rsp_q.result_den <= cmd_i.err ? acc_d_q : wd_q;
      rsp_q.error_flag <= cmd_i.err;
    end
  end

  assign status_o.exp_neg  = exp_q[ExpW-1];
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_one  = (exp_q == ExpW'(1));
  assign status_o.gcd_done = gcd_done;
  assign status_o.g_zero   = (g_q == '0);
  assign out_rsp_o         = rsp_q;

endmodule

// ===== sv/rac_ctrl.sv =====
// Controller FSM: sequences datapath micro-ops per request, owns handshakes.
// Depends on rac_pkg and rational_accumulator_alu_core_defines.svh.
`include "rational_accumulator_alu_core_defines.svh"

module rac_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [rac_pkg::ReqW-1:0]     in_req_type_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  rac_pkg::dp_status_t          status_i,
  output rac_pkg::dp_cmd_t             cmd_o
);
  import rac_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_CLR, S_A1, S_A2, S_A3, S_M1, S_M2, S_D1, S_D2,
    S_PCHK, S_ONE, S_PN, S_PD, S_GRUN, S_GFIN, S_GCHK, S_DIVN, S_FIXN,
    S_DIVD, S_FIXD, S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [ReqW-1:0] kind_q, kind_d;
  logic            err_q, err_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            accept, out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op      = OP_NOP;
    cmd_o.capture = accept;
    cmd_o.commit  = 1'b0;
    cmd_o.err     = err_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d = in_req_type_i;
          err_d  = 1'b0;
          case (in_req_type_i)
            REQ_LOAD:         state_d = S_LOAD;
            REQ_ADD, REQ_SUB: state_d = S_A1;
            REQ_MUL:          state_d = S_M1;
            REQ_DIV:          state_d = S_D1;
            REQ_POWER:        state_d = S_PCHK;
            REQ_REDUCE:       state_d = S_GRUN;
            default:          state_d = S_CLR;
          endcase
        end
      end
      S_LOAD: begin cmd_o.op = OP_LOAD;  state_d = S_DONE; end
      S_CLR:  begin cmd_o.op = OP_CLEAR; state_d = S_DONE; end
      S_A1:   begin cmd_o.op = OP_T1;    state_d = S_A2;   end
      S_A2:   begin cmd_o.op = OP_T2;    state_d = S_A3;   end
      S_A3: begin
        cmd_o.op = (kind_q == REQ_SUB) ? OP_SUB_DQ : OP_ADD_DQ;
        state_d  = S_DONE;
      end
      S_M1:   begin cmd_o.op = OP_NP; state_d = S_M2;   end
      S_M2:   begin cmd_o.op = OP_DQ; state_d = S_DONE; end
      S_D1:   begin cmd_o.op = OP_NQ; state_d = S_D2;   end
      S_D2:   begin cmd_o.op = OP_DP; state_d = S_DONE; end
      S_PCHK: begin
        if (status_i.exp_neg) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else if (status_i.exp_zero) begin
          state_d = S_ONE;
        end else if (status_i.exp_one) begin
          state_d = S_DONE;
        end else begin
          state_d = S_PN;
        end
      end
      S_ONE:  begin cmd_o.op = OP_ONE; state_d = S_DONE; end
      S_PN:   begin cmd_o.op = OP_PN;  state_d = S_PD;   end
      S_PD:   begin cmd_o.op = OP_PD;  state_d = S_PCHK; end
      S_GRUN: begin
        cmd_o.op = OP_GSTEP;
        if (status_i.gcd_done) state_d = S_GFIN;
      end
      S_GFIN: begin cmd_o.op = OP_GFIN; state_d = S_GCHK; end
      S_GCHK: begin
        cmd_o.op = OP_DLOAD;
        cnt_d    = '0;
        if (status_i.g_zero) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_DIVN;
        end
      end
      S_DIVN: begin
        cmd_o.op = OP_DSTEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == '1) state_d = S_FIXN;
      end
      S_FIXN: begin cmd_o.op = OP_FIXN; state_d = S_DIVD; end
      S_DIVD: begin
        cmd_o.op = OP_DSTEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == '1) state_d = S_FIXD;
      end
      S_FIXD: begin cmd_o.op = OP_FIXD; state_d = S_DONE; end
      S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= REQ_CLEAR;
      err_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `RAC_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "request not taken")
  `RAC_ASSERT(a_rise_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "stray result")
  `RAC_ASSERT(a_cnt_idle, (state_q != S_DIVN && state_q != S_DIVD) |-> cnt_q == '0, "div count")
  `RAC_ASSERT(a_err_kind, err_q |-> (kind_q == REQ_POWER || kind_q == REQ_REDUCE), "bad error")

endmodule

// ===== sv/rational_accumulator_alu_core.sv =====
// Top level of the rational accumulator ALU: controller plus datapath.
// Depends on rac_pkg, rac_ctrl and rac_datapath.
//
//  Channel | Signals                              | Direction
//  --------+--------------------------------------+----------
//  request | in_valid_i, in_stall_o, in_req_i     | in
//  result  | out_valid_o, out_stall_i, out_rsp_o  | out
//
// One request at a time; in_stall_o is high from accept until the result is
// written into the output register. Power with e >= 1 runs e - 1 passes of
// numerator product, denominator product and exponent check; e = 0 loads
// 1/1 and a negative exponent fails at the check. Reduce runs the binary GCD
// loop, then two 32-step restoring divisions; reduce of 0/0 fails.
// Reset (async, active low) sets the fraction to 0/1 and empties the output.
// A pending result in the output register does not block the next request;
// a new result waits in the done state while out_stall_i holds the old one.
module rational_accumulator_alu_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rac_pkg::rac_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rac_pkg::rac_rsp_t out_rsp_o
);
  import rac_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: decodes request type into a micro-op sequence
  rac_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_req_i.req_type),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // accumulator, multiplier, GCD and divider
  rac_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_rsp_o (out_rsp_o)
  );

endmodule

// ===== test/rational_accumulator_alu_core_test.sv =====
// Self-checking testbench for rational_accumulator_alu_core.
// It sends directed and random requests, predicts each result fraction, and scores what comes back.
// Depends on rac_pkg and the RTL of the core only.
module rational_accumulator_alu_core_test;
  import rac_pkg::*;

  // Generous bound: the slowest legal run is far below this.
  localparam int CycleLimit   = 1_000_000;
  localparam int DrainCycles  = 1000;  // longer than power with e=127 or a worst-case reduce
  localparam int RandomReqs   = 780;
  localparam int MaxReported  = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  rac_req_t in_req = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  rac_rsp_t out_rsp_o;

  rational_accumulator_alu_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o)
  );

  // Requests not yet presented, and results owed by the core in request order.
  rac_req_t    pending_reqs[$];
  rac_rsp_t    owed_fractions[$];

  // Shadow copy of the running fraction, updated as requests are accepted.
  logic [31:0] shadow_num = 32'd0;
  logic [31:0] shadow_den = 32'd1;

  int total_reqs;
  int accepted;
  int mismatches;
  int cycles;
  int op_seen[8];
  int err_seen;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles: %0d of %0d requests accepted, %0d results owed",
               cycles, accepted, total_reqs, owed_fractions.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Fraction predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Euclid on unsigned magnitudes; gcd(0,0) comes out as zero.
  function automatic logic [31:0] gcd_of(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    while (b != 32'd0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Divide the magnitude, then put the original sign back.
  function automatic logic [31:0] scale_down(input logic [31:0] v, input logic [31:0] g);
    logic [31:0] q;
    q = magnitude(v) / g;
    return v[31] ? (32'd0 - q) : q;
  endfunction

  // Applies one request to the shadow fraction and returns the result the core
  // must report. All products are taken at 32 bits, so they wrap.
  function automatic rac_rsp_t apply_request(input rac_req_t r);
    logic [31:0] n, d, p, q, base_n, base_d, g;
    logic [7:0]  e;
    logic        failed;
    rac_rsp_t    rsp;
    n = shadow_num;
    d = shadow_den;
    p = r.operand_num;
    q = r.operand_den;
    e = r.exponent;
    failed = 1'b0;
    case (r.req_type)
      REQ_LOAD: begin
        n = p;
        d = q;
      end
      REQ_ADD: begin
        n = n * q + d * p;
        d = d * q;
      end
      REQ_SUB: begin
        n = n * q - d * p;
        d = d * q;
      end
      REQ_MUL: begin
        n = n * p;
        d = d * q;
      end
      REQ_DIV: begin
        n = n * q;
        d = d * p;
      end
      REQ_POWER: begin
        if (e[7]) begin
          failed = 1'b1;           // negative exponent
        end else if (e == 8'd0) begin
          n = 32'd1;
          d = 32'd1;
        end else begin
          base_n = n;
          base_d = d;
          for (int k = 1; k < int'(e); k++) begin
            n = n * base_n;
            d = d * base_d;
          end
        end
      end
      REQ_REDUCE: begin
        g = gcd_of(magnitude(n), magnitude(d));
        if (g == 32'd0) begin
          failed = 1'b1;           // 0/0 has no divisor
        end else begin
          n = scale_down(n, g);
          d = scale_down(d, g);
        end
      end
      default: begin
        n = 32'd0;
        d = 32'd1;
      end
    endcase
    if (!failed) begin
      shadow_num = n;
      shadow_den = d;
    end
    rsp.result_num = shadow_num;
    rsp.result_den = shadow_den;
    rsp.error_flag = failed;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_req(input logic [2:0] kind, input logic [31:0] num,
                           input logic [31:0] den, input logic [7:0] e);
    rac_req_t r;
    r.req_type    = kind;
    r.operand_num = num;
    r.operand_den = den;
    r.exponent    = e;
    pending_reqs.push_back(r);
  endtask

  // Small values keep reduce meaningful; corner values and full-width noise
  // make every operand bit toggle.
  function automatic logic [31:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom_range(40) - 20;
    if (sel < 6) begin
      case ($urandom_range(5))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h8000_0000;
        4: return 32'h7FFF_FFFF;
        default: return 32'h0001_0000;
      endcase
    end
    return $urandom();
  endfunction

  // Mostly short powers; long ones are rare since each exponent step adds a pass through the power loop.
  function automatic logic [7:0] pick_exponent();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return 8'($urandom_range(6));
    if (sel < 85) return 8'($urandom_range(255, 128));
    if (sel < 95) return 8'($urandom_range(31, 7));
    return 8'($urandom_range(127, 32));
  endfunction

  function automatic logic [2:0] pick_kind();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return REQ_LOAD;
    if (roll < 29) return REQ_ADD;
    if (roll < 41) return REQ_SUB;
    if (roll < 53) return REQ_MUL;
    if (roll < 65) return REQ_DIV;
    if (roll < 78) return REQ_POWER;
    if (roll < 94) return REQ_REDUCE;
    return REQ_CLEAR;
  endfunction

  task automatic build_stimulus();
    logic [2:0] kind;
    // Directed opening: corners of every field and each special case.
    queue_req(REQ_CLEAR,  32'h1234_5678, 32'h9ABC_DEF0, 8'h55);  // operands ignored
    queue_req(REQ_LOAD,   32'h7FFF_FFFF, 32'h8000_0000, 8'h80);  // field extremes
    queue_req(REQ_REDUCE, 32'h0, 32'h0, 8'h7F);                  // coprime, unchanged
    queue_req(REQ_LOAD,   32'd6, -32'sd4, 8'h00);
    queue_req(REQ_REDUCE, 32'h0, 32'h0, 8'h00);                  // 3/-2, sign kept below
    queue_req(REQ_ADD,    32'd1, 32'd3, 8'h00);
    queue_req(REQ_SUB,    32'd5, 32'd7, 8'h00);
    queue_req(REQ_MUL,    -32'sd2, 32'd9, 8'h00);
    queue_req(REQ_DIV,    32'd4, -32'sd3, 8'h00);
    queue_req(REQ_POWER,  32'h0, 32'h0, 8'd0);                   // anything^0 is 1/1
    queue_req(REQ_LOAD,   -32'sd3, 32'd2, 8'h00);
    queue_req(REQ_POWER,  32'h0, 32'h0, 8'd5);
    queue_req(REQ_POWER,  32'h0, 32'h0, 8'hFF);                  // negative exponent
    queue_req(REQ_POWER,  32'h0, 32'h0, 8'd127);                 // longest power loop
    queue_req(REQ_LOAD,   32'd0, 32'd0, 8'h00);
    queue_req(REQ_REDUCE, 32'h0, 32'h0, 8'h00);                  // 0/0 fails
    queue_req(REQ_LOAD,   -32'sd12, 32'd0, 8'h00);
    queue_req(REQ_REDUCE, 32'h0, 32'h0, 8'h00);                  // sign(n)/0
    queue_req(REQ_LOAD,   32'd0, -32'sd5, 8'h00);
    queue_req(REQ_REDUCE, 32'h0, 32'h0, 8'h00);                  // 0/-1
    queue_req(REQ_LOAD,   32'h8000_0000, 32'h8000_0000, 8'h00);
    queue_req(REQ_REDUCE, 32'h0, 32'h0, 8'h00);                  // most negative over itself
    queue_req(REQ_ADD,    32'd2, 32'd0, 8'h00);                  // zero denominator, no check
    queue_req(REQ_DIV,    32'd0, 32'd5, 8'h00);
    queue_req(REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);

    for (int i = 0; i < RandomReqs; i++) begin
      kind = pick_kind();
      queue_req(kind, pick_operand(), pick_operand(),
                (kind == REQ_POWER) ? pick_exponent() : 8'($urandom()));
    end
    total_reqs = pending_reqs.size();
  endtask

  // Idle mix by progress: sender-light/receiver-heavy, then swapped, then none.
  function automatic int sender_idle_pct();
    if (accepted < total_reqs / 3) return 13;
    if (accepted < 2 * total_reqs / 3) return 71;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (accepted < total_reqs / 3) return 71;
    if (accepted < 2 * total_reqs / 3) return 13;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: one NBA per signal per edge, payload held while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    bit fired;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      fired = in_valid && !in_stall_o;
      if (fired) begin
        owed_fractions.push_back(apply_request(in_req));
        op_seen[in_req.req_type]++;
        accepted++;
      end
      if ((!in_valid || fired) && pending_reqs.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct()) begin
        in_req   <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else if (fired) begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: scores each accepted result against the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : score_results
    rac_rsp_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (owed_fractions.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("[%0d] result with none owed: %0d/%0d err=%0b", cycles,
                     out_rsp_o.result_num, out_rsp_o.result_den, out_rsp_o.error_flag);
        end else begin
          want = owed_fractions.pop_front();
          if (want.error_flag) err_seen++;
          if (out_rsp_o.result_num !== want.result_num ||
              out_rsp_o.result_den !== want.result_den ||
              out_rsp_o.error_flag !== want.error_flag) begin
            mismatches++;
            if (mismatches <= MaxReported)
              $display("[%0d] result differs: want %0d/%0d err=%0b, got %0d/%0d err=%0b",
                       cycles, want.result_num, want.result_den, want.error_flag,
                       out_rsp_o.result_num, out_rsp_o.result_den, out_rsp_o.error_flag);
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, stimulus, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted < total_reqs) @(posedge clk_i);
    while (owed_fractions.size() != 0) @(posedge clk_i);
    // Catch any stray extra result the core might still emit.
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d requests in %0d cycles: load %0d add %0d sub %0d mul %0d div %0d",
             accepted, cycles, op_seen[REQ_LOAD], op_seen[REQ_ADD], op_seen[REQ_SUB],
             op_seen[REQ_MUL], op_seen[REQ_DIV]);
    $display("  power %0d reduce %0d clear %0d; %0d error responses; %0d mismatches",
             op_seen[REQ_POWER], op_seen[REQ_REDUCE], op_seen[REQ_CLEAR], err_seen,
             mismatches);
    if (mismatches == 0 && owed_fractions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
